FILE: hw/rtl/xsb_pkg.sv
// shared constants, command codes and inter-module structs of the xor sprite blitter
`timescale 1ns / 1ps
package xsb_pkg;

  localparam int unsigned LINE_PIXELS = 160;
  localparam int unsigned LINE_COUNT  = 256;
  localparam int unsigned STORE_SIZE  = LINE_PIXELS * LINE_COUNT;
  localparam int unsigned PIX_W       = 4;
  localparam int unsigned MEM_AW      = $clog2(STORE_SIZE);
  // a sprite may run on past the end of the store: start row 255, 255 rows, wide rows
  localparam int unsigned WADDR_MAX   = 2 * 255 * LINE_PIXELS + 2 * 256;
  localparam int unsigned WADDR_W     = $clog2(WADDR_MAX);

  localparam logic [7:0] FLIP_MASK = 8'hFF;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // one pixel operation handed from the sequencer to the write-back stage
  typedef struct packed {
    logic              valid;
    logic              is_read;
    logic              in_range;
    logic              set_bit;
    logic [MEM_AW-1:0] addr;
    logic [PIX_W-1:0]  color;
  } rmw_op_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
  } rd_res_t;

endpackage

FILE: hw/rtl/xor_sprite_blitter.sv
// Top level of the xor sprite blitter: command sequencer, frame store, output register.
// A data byte issues one pixel per cycle to the frame store's single write port until its
// eight bits are done or the sprite's last row ends inside the byte; bytes that fall outside
// a sprite issue no pixel. Each pixel is read, xored and written back in a two-stage loop
// with forwarding, so a new pixel enters every cycle. A read result is registered in the
// write-back stage and then in the output register, and may wait there while further
// transactions are taken. After reset and after every clear command the store is swept to
// zero, one pixel a cycle; no transaction is taken during the sweep.
`timescale 1ns / 1ps
module xor_sprite_blitter
  import xsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[7:0], pos_y[15:8], sprite_width[23:16], sprite_height[31:24],
  // color[35:32], data_byte[43:36], zero fill[47:44]
  input  logic [47:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel[3:0], zero fill[7:4]
  output logic [7:0]  m_axis_tdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BITS  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [WADDR_W-1:0] waddr_q, waddr_d;
  logic [7:0]         col_left_q, col_left_d;
  logic [7:0]         rows_left_q, rows_left_d;
  logic [7:0]         row_width_q, row_width_d;
  logic [PIX_W-1:0]   color_q, color_d;
  logic [6:0]         shift_q, shift_d;
  logic [2:0]         bits_left_q, bits_left_d;
  logic [MEM_AW-1:0]  clr_addr_q, clr_addr_d;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   out_pixel_q, out_pixel_d;
  logic               skid_valid_q, skid_valid_d;
  logic [PIX_W-1:0]   skid_pixel_q, skid_pixel_d;

  cmd_e               cmd;
  logic [7:0]         in_px, in_py, in_w, in_h, in_byte;
  logic [PIX_W-1:0]   in_color;
  logic               accept, out_take;
  logic               issue_bit, cur_bit, bit_in_range;
  logic [WADDR_W-1:0] step_addr;
  logic [7:0]         step_col, step_rows;
  logic [WADDR_W-1:0] rd_full_addr;
  logic               rd_in_range;

  rmw_op_t            op;
  ram_wr_t            rmw_wr;
  rd_res_t            rd_res;
  logic               ram_we, ram_re;
  logic [MEM_AW-1:0]  ram_waddr, ram_raddr;
  logic [PIX_W-1:0]   ram_wdata, ram_rdata;

  assign cmd      = cmd_e'(s_axis_tuser);
  assign in_px    = s_axis_tdata[7:0];
  assign in_py    = s_axis_tdata[15:8];
  assign in_w     = s_axis_tdata[23:16];
  assign in_h     = s_axis_tdata[31:24];
  assign in_color = s_axis_tdata[35:32];
  assign in_byte  = s_axis_tdata[43:36];

  assign s_axis_tready = (state_q == ST_IDLE) && !skid_valid_q && !(out_valid_q && rd_res.valid);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_take      = m_axis_tvalid && m_axis_tready;

  assign issue_bit = (state_q == ST_BITS) ||
                     (accept && (cmd == CMD_DATA) && (row_width_q != '0) && (rows_left_q != '0));
  assign cur_bit      = (state_q == ST_BITS) ? shift_q[6] : in_byte[7];
  assign bit_in_range = waddr_q < WADDR_W'(STORE_SIZE);

  // one pixel step; at a row end jump back by the width and down one line
  always_comb begin
    step_rows = rows_left_q;
    if (col_left_q == 8'd1) begin
      step_addr = waddr_q + WADDR_W'(LINE_PIXELS + 1) - WADDR_W'(row_width_q);
      step_col  = row_width_q;
      step_rows = rows_left_q - 8'd1;
    end else begin
      step_addr = waddr_q + WADDR_W'(1);
      step_col  = col_left_q - 8'd1;
    end
  end

  assign rd_full_addr = WADDR_W'(in_px) + WADDR_W'(in_py * LINE_PIXELS);
  assign rd_in_range  = rd_full_addr < WADDR_W'(STORE_SIZE);

  always_comb begin
    op.valid    = 1'b0;
    op.is_read  = 1'b0;
    op.in_range = bit_in_range;
    op.set_bit  = cur_bit;
    op.addr     = waddr_q[MEM_AW-1:0];
    op.color    = color_q;
    ram_re      = 1'b0;
    ram_raddr   = waddr_q[MEM_AW-1:0];
    if (issue_bit) begin
      op.valid = 1'b1;
      ram_re   = bit_in_range && cur_bit;
    end else if (accept && (cmd == CMD_READ)) begin
      op.valid    = 1'b1;
      op.is_read  = 1'b1;
      op.in_range = rd_in_range;
      op.addr     = rd_full_addr[MEM_AW-1:0];
      ram_re      = rd_in_range;
      ram_raddr   = rd_full_addr[MEM_AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    waddr_d     = waddr_q;
    col_left_d  = col_left_q;
    rows_left_d = rows_left_q;
    row_width_d = row_width_q;
    color_d     = color_q;
    shift_d     = shift_q;
    bits_left_d = bits_left_q;
    clr_addr_d  = clr_addr_q;

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + MEM_AW'(1);
        if (clr_addr_q == MEM_AW'(STORE_SIZE - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_BEGIN: begin
              waddr_d     = WADDR_W'(in_px) + WADDR_W'((in_py ^ FLIP_MASK) * LINE_PIXELS);
              row_width_d = in_w;
              col_left_d  = in_w;
              rows_left_d = in_h;
              color_d     = in_color;
            end
            CMD_DATA: begin
              if (issue_bit) begin
                waddr_d     = step_addr;
                col_left_d  = step_col;
                rows_left_d = step_rows;
                shift_d     = in_byte[6:0];
                bits_left_d = 3'd7;
                if (step_rows != '0) begin
                  state_d = ST_BITS;
                end
              end
            end
            CMD_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_BITS: begin
        waddr_d     = step_addr;
        col_left_d  = step_col;
        rows_left_d = step_rows;
        shift_d     = {shift_q[5:0], 1'b0};
        bits_left_d = bits_left_q - 3'd1;
        // the rest of the byte is dropped once the last row is done
        if ((bits_left_q == 3'd1) || (step_rows == '0)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_pixel_d  = out_pixel_q;
    skid_valid_d = skid_valid_q;
    skid_pixel_d = skid_pixel_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_pixel_d  = skid_pixel_q;
        skid_valid_d = 1'b0;
      end else if (rd_res.valid) begin
        out_valid_d = 1'b1;
        out_pixel_d = rd_res.pixel;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (rd_res.valid) begin
      skid_valid_d = 1'b1;
      skid_pixel_d = rd_res.pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      waddr_q      <= '0;
      col_left_q   <= '0;
      rows_left_q  <= '0;
      row_width_q  <= '0;
      color_q      <= '0;
      bits_left_q  <= '0;
      clr_addr_q   <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      waddr_q      <= waddr_d;
      col_left_q   <= col_left_d;
      rows_left_q  <= rows_left_d;
      row_width_q  <= row_width_d;
      color_q      <= color_d;
      bits_left_q  <= bits_left_d;
      clr_addr_q   <= clr_addr_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q      <= shift_d;
    out_pixel_q  <= out_pixel_d;
    skid_pixel_q <= skid_pixel_d;
  end

  xsb_pixel_rmw u_rmw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .flush_i  (accept && (cmd == CMD_CLEAR)),
    .rdata_i  (ram_rdata),
    .wr_o     (rmw_wr),
    .rd_res_o (rd_res)
  );

  assign ram_we    = (state_q == ST_CLEAR) || rmw_wr.en;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : rmw_wr.addr;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : rmw_wr.data;

  xsb_frame_ram #(
    .Depth (STORE_SIZE),
    .Width (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_pixel_q};

endmodule

FILE: hw/rtl/xsb_frame_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps
module xsb_frame_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/xsb_pixel_rmw.sv
// write-back stage: xors the color into returned pixels, forwards the last write
`timescale 1ns / 1ps
module xsb_pixel_rmw
  import xsb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rmw_op_t          op_i,
  input  logic             flush_i,
  input  logic [PIX_W-1:0] rdata_i,
  output ram_wr_t          wr_o,
  output rd_res_t          rd_res_o
);

  rmw_op_t           op_q;
  logic              lastw_valid_q, lastw_valid_d;
  logic [MEM_AW-1:0] lastw_addr_q, lastw_addr_d;
  logic [PIX_W-1:0]  lastw_data_q, lastw_data_d;
  logic [PIX_W-1:0]  base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q.valid    <= 1'b0;
      lastw_valid_q <= 1'b0;
    end else begin
      op_q          <= op_i;
      lastw_valid_q <= lastw_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lastw_addr_q <= lastw_addr_d;
    lastw_data_q <= lastw_data_d;
  end

  // the ram read issued alongside the previous write misses it
  assign base = (lastw_valid_q && (lastw_addr_q == op_q.addr)) ? lastw_data_q : rdata_i;

  always_comb begin
    wr_o.en   = op_q.valid && !op_q.is_read && op_q.in_range && op_q.set_bit;
    wr_o.addr = op_q.addr;
    wr_o.data = base ^ op_q.color;

    rd_res_o.valid = op_q.valid && op_q.is_read;
    rd_res_o.pixel = op_q.in_range ? base : '0;

    lastw_valid_d = lastw_valid_q;
    lastw_addr_d  = lastw_addr_q;
    lastw_data_d  = lastw_data_q;
    if (flush_i) begin
      lastw_valid_d = 1'b0;
    end else if (wr_o.en) begin
      lastw_valid_d = 1'b1;
      lastw_addr_d  = wr_o.addr;
      lastw_data_d  = wr_o.data;
    end
  end

endmodule

FILE: test/tb_xor_sprite_blitter.sv
// self-checking testbench of the xor sprite blitter with a pixel-accurate frame store predictor
`timescale 1ns / 1ps
module tb_xor_sprite_blitter;
  import xsb_pkg::*;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] width;
    logic [7:0] height;
    logic [3:0] color;
    logic [7:0] data;
  } blit_item_t;

  class blit_scoreboard;
    bit [3:0]    pixels [STORE_SIZE];
    int unsigned wr_addr;
    int unsigned col_left;
    int unsigned rows_left;
    int unsigned row_width;
    bit [3:0]    ink;
    bit [3:0]    pixel_q [$];
    int          errors;

    function new();
      wr_addr   = 0;
      col_left  = 0;
      rows_left = 0;
      row_width = 0;
      ink       = '0;
      errors    = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void plot(bit set);
      if (set && wr_addr < STORE_SIZE) pixels[wr_addr] = pixels[wr_addr] ^ ink;
      wr_addr++;
      col_left--;
      // end of a sprite row: back to the row start, one store line down
      if (col_left == 0) begin
        wr_addr   = wr_addr - row_width + LINE_PIXELS;
        col_left  = row_width;
        rows_left--;
      end
    endfunction

    function void note_input(blit_item_t it);
      int unsigned addr;
      case (it.cmd)
        CMD_BEGIN: begin
          wr_addr   = int'(it.pos_x) + int'(it.pos_y ^ FLIP_MASK) * LINE_PIXELS;
          row_width = 32'(it.width);
          col_left  = 32'(it.width);
          rows_left = 32'(it.height);
          ink       = it.color;
        end
        CMD_DATA: begin
          if (row_width != 0) begin
            for (int i = 7; i >= 0; i--) begin
              if (rows_left == 0) break;
              plot(it.data[i]);
            end
          end
        end
        CMD_CLEAR: begin
          foreach (pixels[i]) pixels[i] = '0;
        end
        default: begin
          addr = int'(it.pos_x) + int'(it.pos_y) * LINE_PIXELS;
          pixel_q.push_back((addr < STORE_SIZE) ? pixels[addr] : 4'h0);
        end
      endcase
    endfunction

    task check_pixel(bit [3:0] got);
      bit [3:0] want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel %0h with no read pending", got));
      end else begin
        want = pixel_q.pop_front();
        if (got != want) report($sformatf("pixel %0h, expected %0h", got, want));
      end
    endtask

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;

  blit_scoreboard sb = new();

  int n_sent      = 0;
  int tx_run      = 0;
  bit tx_quiet    = 1'b0;
  int rx_run      = 0;
  bit rx_quiet    = 1'b0;
  bit hold_req    = 1'b0;
  bit rx_hold_done = 1'b0;

  xor_sprite_blitter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle cycles before the next transaction, in stretches of busy or quiet behavior
  function automatic int pick_gap(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 40);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic blit_item_t mk(cmd_e c, int px, int py, int w, int h, int col, int db);
    blit_item_t it;
    it.cmd    = c;
    it.pos_x  = 8'(px);
    it.pos_y  = 8'(py);
    it.width  = 8'(w);
    it.height = 8'(h);
    it.color  = 4'(col);
    it.data   = 8'(db);
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send(input blit_item_t it);
    int gap;
    gap = pick_gap(tx_run, tx_quiet);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = it.cmd;
    s_axis_tdata  = {4'h0, it.data, it.color, it.height, it.width, it.pos_y, it.pos_x};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
    n_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata[3:0]);
  end

  // result side
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // long hold-off so that the output register fills and the input stalls
      if (!rx_hold_done && hold_req) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        rx_hold_done  = 1'b1;
      end
      gap = pick_gap(rx_run, rx_quiet);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int px, row, w, h, nbytes, sel, cls, clears, next_drain, db;
    bit [3:0] ink;
    bit burst_done;
    cmd_e c;

    clears     = 0;
    next_drain = 300;
    burst_done = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_BEGIN;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_BEGIN, 0, 255, 8, 1, 15, 0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hff));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 7, 0, 0, 0, 0, 0));
    // start column near the line end runs on into the next line; last row ends mid-byte
    send(mk(CMD_BEGIN, 155, 255, 10, 2, 4'ha, 0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hff));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'h00));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hf0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hff));
    send(mk(CMD_READ, 159, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 3, 2, 0, 0, 0, 0));
    // bottom line, writes past the end of the store
    send(mk(CMD_BEGIN, 159, 0, 160, 2, 5, 8'hff));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'haa));
    send(mk(CMD_READ, 159, 255, 0, 0, 0, 0));
    send(mk(CMD_READ, 255, 255, 0, 0, 0, 0));
    // zero width and zero height ignore data
    send(mk(CMD_BEGIN, 20, 200, 0, 5, 0, 0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hff));
    send(mk(CMD_BEGIN, 255, 200, 5, 0, 9, 0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'hff));
    // row wider than a line
    send(mk(CMD_BEGIN, 0, 245, 255, 255, 3, 0));
    send(mk(CMD_DATA, 0, 0, 0, 0, 0, 8'h5f));
    send(mk(CMD_READ, 3, 10, 0, 0, 0, 0));
    send(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0));

    // random part
    while (n_sent < 1450) begin
      if (!burst_done && n_sent >= 700) begin
        // the receiver holds off once this burst starts, so the reads back up
        hold_req = 1'b1;
        repeat (16) send(mk(CMD_READ, $urandom_range(0, 159), $urandom_range(0, 255), 0, 0, 0, 0));
        burst_done = 1'b1;
      end else if (clears < 3 && n_sent >= 400 * (clears + 1)) begin
        send(mk(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 0, 0));
        clears++;
      end else if (n_sent >= next_drain) begin
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
        next_drain += 300;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          cls = $urandom_range(0, 99);
          if (cls < 80) begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 10);
          end else if (cls < 88) begin
            w = $urandom_range(100, 255);
            h = $urandom_range(1, 2);
          end else if (cls < 94) begin
            w = $urandom_range(1, 3);
            h = $urandom_range(100, 255);
          end else begin
            w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
            h = (w == 0) ? $urandom_range(0, 10) : 0;
          end
          px  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 159);
          row = $urandom_range(0, 255);
          ink = 4'($urandom_range(0, 15));
          nbytes = (w * h + 7) / 8;
          if (nbytes == 0) nbytes = $urandom_range(1, 3);
          cls = $urandom_range(0, 9);
          if (cls == 0) nbytes = $urandom_range(0, nbytes);
          else if (cls == 1) nbytes += $urandom_range(1, 3);
          send(mk(CMD_BEGIN, px, row ^ 255, w, h, ink, $urandom_range(0, 255)));
          repeat (nbytes) begin
            cls = $urandom_range(0, 6);
            db  = (cls == 0) ? 8'hff : (cls == 1) ? 8'h00 : $urandom_range(0, 255);
            send(mk(CMD_DATA, 0, 0, 0, 0, 0, db));
          end
          repeat ($urandom_range(1, 4)) begin
            send(mk(CMD_READ, px + $urandom_range(0, (w > 0) ? w - 1 : 0),
                    row + $urandom_range(0, (h > 0) ? h - 1 : 0), 0, 0, 0, 0));
          end
        end else if (sel < 88) begin
          // fully random transactions, clear left out
          repeat ($urandom_range(1, 5)) begin
            cls = $urandom_range(0, 2);
            c = (cls == 0) ? CMD_BEGIN : (cls == 1) ? CMD_DATA : CMD_READ;
            send(mk(c, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 255)));
          end
        end else begin
          repeat ($urandom_range(4, 12)) begin
            send(mk(CMD_READ, $urandom_range(0, 159), $urandom_range(0, 255), 0, 0, 0, 0));
          end
        end
      end
    end

    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
